// ===== rtl/ansi_tcp_pkg.sv =====
// Shared types, codes and constants of the ANSI text console parser.
`default_nettype none

package ansi_tcp_pkg;

  // Default geometry, in pixels
  localparam int TAB_WIDTH_DEF   = 32;
  localparam int LINE_HEIGHT_DEF = 16;
  localparam int GLYPH_WIDTH_DEF = 8;

  // Coordinate width and saturation value
  localparam int          XY_W      = 12;
  localparam logic [11:0] COORD_MAX = 12'hFFF;

  // Configuration register indexes and reset values
  localparam logic        CFG_SCREEN_WIDTH = 1'b0;
  localparam logic        CFG_LINE_COUNT   = 1'b1;
  localparam logic [11:0] SCREEN_WIDTH_RST = 12'd800;
  localparam logic [7:0]  LINE_COUNT_RST   = 8'd37;

  // Control and command bytes
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_BEL      = 8'h07;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_FF       = 8'h0C;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_CMD_K    = 8'h4B;
  localparam logic [7:0] CH_CMD_G    = 8'h47;
  localparam logic [7:0] CH_CMD_M    = 8'h6D;

  // Attribute codes of the m command
  localparam logic [6:0] SGR_RESET         = 7'd0;
  localparam logic [6:0] SGR_BOLD          = 7'd1;
  localparam logic [6:0] SGR_UNDERLINE     = 7'd4;
  localparam logic [6:0] SGR_REVERSE       = 7'd7;
  localparam logic [6:0] SGR_BOLD_OFF      = 7'd21;
  localparam logic [6:0] SGR_UNDERLINE_OFF = 7'd24;
  localparam logic [6:0] SGR_REVERSE_OFF   = 7'd27;
  localparam logic [6:0] SGR_FG_FIRST      = 7'd30;
  localparam logic [6:0] SGR_FG_LAST       = 7'd37;
  localparam logic [6:0] SGR_BG_FIRST      = 7'd40;
  localparam logic [6:0] SGR_BG_LAST       = 7'd47;

  localparam logic [3:0] COLOR_FG_RST = 4'd0;
  localparam logic [3:0] COLOR_BG_RST = 4'd15;

  // Result queue depth
  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = $clog2(RES_DEPTH);

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_BRACKET,
    PH_DIGITS
  } phase_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_GLYPH  = 3'd1,
    ACT_CLREOL = 3'd2,
    ACT_CLS    = 3'd3,
    ACT_SCROLL = 3'd4,
    ACT_BEEP   = 3'd5
  } act_t;

  typedef struct packed {
    act_t        act;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  glyph;
    logic [3:0]  fore;
    logic [3:0]  back;
    logic        bold;
    logic        underline;
    logic        last;
  } res_t;

  // Up to two results per byte travel to the queue together
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // ANSI colour number to VGA colour order
  function automatic logic [3:0] ansi_to_vga(input logic [2:0] a);
    logic [3:0] v;
    case (a)
      3'd0: v = 4'd0;
      3'd1: v = 4'd4;
      3'd2: v = 4'd2;
      3'd3: v = 4'd6;
      3'd4: v = 4'd1;
      3'd5: v = 4'd5;
      3'd6: v = 4'd3;
      3'd7: v = 4'd7;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ansi_tcp_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one a cycle while not stalled.
`default_nettype none

module ansi_tcp_fifo
  import ansi_tcp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  output res_t       head,
  output logic       head_valid,
  input  wire logic  head_stall
);

  res_t              mem_r [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_AW:0]   count_r, count_nxt;
  logic              pop;

  // Status towards both sides
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign room       = (count_r <= (RES_AW + 1)'(RES_DEPTH - 2));
  assign pop        = head_valid && !head_stall;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_AW'(push.n);
    rd_ptr_nxt = pop ? rd_ptr_r + RES_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (RES_AW + 1)'(push.n) - (RES_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the results of one byte in order
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_r + RES_AW'(1)] <= push.r1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ansi_tcp_core.sv =====
// Input register, console state and per-byte command decoding.
`default_nettype none

module ansi_tcp_core
  import ansi_tcp_pkg::*;
#(
  parameter int TAB_WIDTH   = TAB_WIDTH_DEF,
  parameter int LINE_HEIGHT = LINE_HEIGHT_DEF,
  parameter int GLYPH_WIDTH = GLYPH_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_in,
  input  wire logic        room,
  output push_t            push
);

  // Tab stop by reciprocal multiplication; exact for 12-bit columns
  localparam int TAB_SHIFT = 21;
  localparam int TAB_RECIP = ((1 << TAB_SHIFT) + TAB_WIDTH - 1) / TAB_WIDTH;
  localparam int TAB_PW    = TAB_SHIFT + XY_W;

  // Configuration
  logic [11:0] sw_r;
  logic [7:0]  lc_r;

  // Input stage
  logic        hold_r;
  logic [7:0]  char_r;
  logic        process;

  // Console state
  phase_t      phase_r, phase_nxt;
  logic [6:0]  num_r, num_nxt;
  logic        two_r, two_nxt;
  logic [11:0] cx_r, cx_nxt;
  logic [11:0] cy_r, cy_nxt;
  logic        bold_r, bold_nxt;
  logic        ul_r, ul_nxt;
  logic        rev_r, rev_nxt;
  logic [3:0]  fg_r, fg_nxt;
  logic [3:0]  bg_r, bg_nxt;

  // Tab unit
  logic              tab_pend_r;
  logic [11:0]       tab_q_r;
  logic [TAB_PW-1:0] tab_prod;
  logic [21:0]       tab_stop;
  logic [11:0]       tab_x;
  logic              tab_go;

  // Decode
  logic        digit;
  logic [3:0]  dig;
  logic        text_go;
  logic        cmd_go;
  logic [6:0]  cmd_val;
  logic [6:0]  fg_idx, bg_idx;

  // Line and glyph geometry
  logic [7:0]  lc_less;
  logic [13:0] nl_lim;
  logic        nl_adv;
  logic [11:0] cy_down;
  logic        wrap;
  logic [11:0] gx;
  logic [12:0] gx_sum;

  // Results
  res_t        r0, r1;
  logic [1:0]  n;
  res_t        glyph_res;

  assign process  = hold_r && room && !tab_pend_r;
  assign in_stall = hold_r && !process;

  assign digit = (char_r inside {[CH_ZERO:CH_NINE]});
  assign dig   = 4'(char_r - CH_ZERO);

  // Tab quotient now, stop position in the next cycle
  assign tab_prod = TAB_PW'(cx_r) * TAB_PW'(TAB_RECIP);
  assign tab_stop = 22'({1'b0, tab_q_r} + 13'd1) * 22'(TAB_WIDTH);
  assign tab_x    = (tab_stop > 22'(COORD_MAX)) ? COORD_MAX : tab_stop[11:0];

  // New line: advance unless on the last row or past the coordinate range
  assign lc_less = lc_r - 8'd1;
  assign nl_lim  = 14'(lc_less) * 14'(LINE_HEIGHT);
  assign nl_adv  = (lc_r != 8'd0) && ({2'b00, cy_r} < nl_lim) &&
                   (({1'b0, cy_r} + 13'(LINE_HEIGHT)) <= 13'(COORD_MAX));
  assign cy_down = cy_r + 12'(LINE_HEIGHT);

  // Wrap before the right edge, then draw at the line start
  assign wrap   = ({1'b0, cx_r} + 13'(GLYPH_WIDTH)) >= {1'b0, sw_r};
  assign gx     = wrap ? 12'd0 : cx_r;
  assign gx_sum = {1'b0, gx} + 13'(GLYPH_WIDTH);

  assign fg_idx = cmd_val - SGR_FG_FIRST;
  assign bg_idx = cmd_val - SGR_BG_FIRST;

  // Parse phase transitions and escape number
  always_comb begin
    phase_nxt = phase_r;
    num_nxt   = num_r;
    two_nxt   = two_r;
    text_go   = 1'b0;
    cmd_go    = 1'b0;
    cmd_val   = '0;
    if (char_r != CH_NUL) begin
      case (phase_r)
        PH_ESC: begin
          if (char_r == CH_LBRACKET) begin
            phase_nxt = PH_BRACKET;
            num_nxt   = '0;
            two_nxt   = 1'b0;
          end else begin
            phase_nxt = PH_TEXT;
            text_go   = 1'b1;
          end
        end
        PH_BRACKET: begin
          if (digit) begin
            phase_nxt = PH_DIGITS;
            num_nxt   = 7'(dig);
            two_nxt   = 1'b0;
          end else begin
            phase_nxt = PH_TEXT;
            cmd_go    = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (digit && !two_r) begin
            num_nxt = 7'(num_r * 7'd10 + 7'(dig));
            two_nxt = 1'b1;
          end else begin
            phase_nxt = PH_TEXT;
            cmd_go    = 1'b1;
            cmd_val   = num_r;
          end
        end
        default: begin
          text_go = 1'b1;
        end
      endcase
      if (text_go && char_r == CH_ESC) begin
        phase_nxt = PH_ESC;
      end
    end
  end

  // Cursor, attributes and results of one byte
  always_comb begin
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    bold_nxt = bold_r;
    ul_nxt   = ul_r;
    rev_nxt  = rev_r;
    fg_nxt   = fg_r;
    bg_nxt   = bg_r;
    tab_go   = 1'b0;
    r0       = '0;
    r1       = '0;
    n        = 2'd0;

    glyph_res           = '0;
    glyph_res.act       = ACT_GLYPH;
    glyph_res.pos_x     = gx;
    glyph_res.pos_y     = (wrap && nl_adv) ? cy_down : cy_r;
    glyph_res.glyph     = char_r;
    glyph_res.fore      = rev_r ? bg_r : fg_r;
    glyph_res.back      = rev_r ? fg_r : bg_r;
    glyph_res.bold      = bold_r;
    glyph_res.underline = ul_r;

    if (text_go) begin
      case (char_r)
        CH_BEL: begin
          r0.act = ACT_BEEP;
          n      = 2'd1;
        end
        CH_TAB: begin
          tab_go = 1'b1;
        end
        CH_FF: begin
          cx_nxt = '0;
          cy_nxt = '0;
          r0.act = ACT_CLS;
          n      = 2'd1;
        end
        CH_ESC: begin
        end
        CH_LF: begin
          cx_nxt = '0;
          if (nl_adv) begin
            cy_nxt = cy_down;
          end else begin
            r0.act   = ACT_SCROLL;
            r0.pos_y = cy_r;
            n        = 2'd1;
          end
        end
        CH_CR: begin
          cx_nxt   = '0;
          r0.act   = ACT_CLREOL;
          r0.pos_y = cy_r;
          n        = 2'd1;
        end
        default: begin
          cx_nxt = (gx_sum > 13'(COORD_MAX)) ? COORD_MAX : gx_sum[11:0];
          if (wrap) begin
            cy_nxt = glyph_res.pos_y;
          end
          if (wrap && !nl_adv) begin
            r0.act   = ACT_SCROLL;
            r0.pos_y = cy_r;
            r1       = glyph_res;
            n        = 2'd2;
          end else begin
            r0 = glyph_res;
            n  = 2'd1;
          end
        end
      endcase
    end else if (cmd_go) begin
      case (char_r)
        CH_CMD_K: begin
          r0.act   = ACT_CLREOL;
          r0.pos_x = cx_r;
          r0.pos_y = cy_r;
          n        = 2'd1;
        end
        CH_CMD_G: begin
          cx_nxt = 12'({5'b0, cmd_val} * 12'(GLYPH_WIDTH));
        end
        CH_CMD_M: begin
          if (cmd_val == SGR_RESET) begin
            bold_nxt = 1'b0;
            ul_nxt   = 1'b0;
            rev_nxt  = 1'b0;
            fg_nxt   = COLOR_FG_RST;
            bg_nxt   = COLOR_BG_RST;
          end else if (cmd_val == SGR_BOLD) begin
            bold_nxt = 1'b1;
          end else if (cmd_val == SGR_UNDERLINE) begin
            ul_nxt = 1'b1;
          end else if (cmd_val == SGR_REVERSE) begin
            rev_nxt = 1'b1;
          end else if (cmd_val == SGR_BOLD_OFF) begin
            bold_nxt = 1'b0;
          end else if (cmd_val == SGR_UNDERLINE_OFF) begin
            ul_nxt = 1'b0;
          end else if (cmd_val == SGR_REVERSE_OFF) begin
            rev_nxt = 1'b0;
          end else if (cmd_val inside {[SGR_FG_FIRST:SGR_FG_LAST]}) begin
            fg_nxt = ansi_to_vga(fg_idx[2:0]);
          end else if (cmd_val inside {[SGR_BG_FIRST:SGR_BG_LAST]}) begin
            bg_nxt = ansi_to_vga(bg_idx[2:0]);
          end
        end
        default: begin
        end
      endcase
    end

    // A byte with no visible effect still yields one empty result
    if (n == 2'd0) begin
      r0.act = ACT_NONE;
      n      = 2'd1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

  assign push.n  = process ? n : 2'd0;
  assign push.r0 = r0;
  assign push.r1 = r1;

  // Control and console state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r       <= SCREEN_WIDTH_RST;
      lc_r       <= LINE_COUNT_RST;
      hold_r     <= 1'b0;
      tab_pend_r <= 1'b0;
      phase_r    <= PH_TEXT;
      num_r      <= '0;
      two_r      <= 1'b0;
      cx_r       <= '0;
      cy_r       <= '0;
      bold_r     <= 1'b0;
      ul_r       <= 1'b0;
      rev_r      <= 1'b0;
      fg_r       <= COLOR_FG_RST;
      bg_r       <= COLOR_BG_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH: sw_r <= cfg_data;
          CFG_LINE_COUNT:   lc_r <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        hold_r <= 1'b1;
      end else if (process) begin
        hold_r <= 1'b0;
      end
      tab_pend_r <= process && tab_go;
      if (process) begin
        phase_r <= phase_nxt;
        num_r   <= num_nxt;
        two_r   <= two_nxt;
        cx_r    <= cx_nxt;
        cy_r    <= cy_nxt;
        bold_r  <= bold_nxt;
        ul_r    <= ul_nxt;
        rev_r   <= rev_nxt;
        fg_r    <= fg_nxt;
        bg_r    <= bg_nxt;
      end else if (tab_pend_r) begin
        cx_r <= tab_x;
      end
    end
  end

  // Hold the input byte and the tab quotient
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r <= in_char_in;
    end
    if (process && tab_go) begin
      tab_q_r <= tab_prod[TAB_PW-1:TAB_SHIFT];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ansi_text_console_parser_unit.sv =====
// ANSI text console parser: turns a byte stream into console drawing commands.
//
// Input channel: one text byte per transaction on in_valid / in_stall.
// Result channel: drawing commands on out_valid / out_stall; each byte gives
// one or two results, the final one marked by out_last.
// Configuration: cfg_we with cfg_index 0 writes the screen width in pixels,
// index 1 the number of text rows; write only while the block is idle.
// Path: a taken byte is held in the input register and its results are then
// written into the result queue, whose head drives the result ports.
// Throughput: one byte per cycle while the queue has room; a tab holds the
// state update unit while the stop is computed (quotient multiply, then stop
// multiply), and a wrap that scrolls puts two results on the result channel.
// A four-entry result queue parts the two sides; input is held while fewer
// than two entries are free, so a stalled receiver fills the queue and then
// stalls the sender without losing anything.
// Reset (rst_n low, synchronous) empties the queue, homes the cursor, clears
// the attributes to black on white and restores the default geometry.
`default_nettype none

module ansi_text_console_parser_unit
  import ansi_tcp_pkg::*;
#(
  parameter int TAB_WIDTH   = TAB_WIDTH_DEF,
  parameter int LINE_HEIGHT = LINE_HEIGHT_DEF,
  parameter int GLYPH_WIDTH = GLYPH_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_action,
  output logic [11:0]      out_pos_x,
  output logic [11:0]      out_pos_y,
  output logic [7:0]       out_glyph,
  output logic [3:0]       out_fore,
  output logic [3:0]       out_back,
  output logic             out_bold,
  output logic             out_underline,
  output logic             out_last
);

  push_t push;
  logic  room;
  res_t  head;

  ansi_tcp_core #(
    .TAB_WIDTH   (TAB_WIDTH),
    .LINE_HEIGHT (LINE_HEIGHT),
    .GLYPH_WIDTH (GLYPH_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .room       (room),
    .push       (push)
  );

  ansi_tcp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head       (head),
    .head_valid (out_valid),
    .head_stall (out_stall)
  );

  // Unpack the queue head onto the result ports
  assign out_action    = head.act;
  assign out_pos_x     = head.pos_x;
  assign out_pos_y     = head.pos_y;
  assign out_glyph     = head.glyph;
  assign out_fore      = head.fore;
  assign out_back      = head.back;
  assign out_bold      = head.bold;
  assign out_underline = head.underline;
  assign out_last      = head.last;

endmodule

`default_nettype wire
